@@ sv/boolean_input_debounce_bank_top_macros.svh @@
// Assertion macros for the debounce bank checker.
// Used by bidb_checker.sv; no other dependencies.
`ifndef BOOLEAN_INPUT_DEBOUNCE_BANK_TOP_MACROS_SVH
`define BOOLEAN_INPUT_DEBOUNCE_BANK_TOP_MACROS_SVH

// Clocked property, quiet while reset is held.
`define BIDB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication from one cycle to the next.
`define BIDB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/bidb_pkg.sv @@
// Shared types and constants of the debounce bank.
// No dependencies; imported by every module of the block.
package bidb_pkg;

  localparam int unsigned LaneCountDefault = 8;
  localparam int unsigned PinWidth         = 8;
  localparam int unsigned CntWidth         = 8;
  localparam int unsigned CfgIndexWidth    = 3;
  localparam int unsigned CfgDataWidth     = 8;

  localparam logic [CntWidth-1:0] CountLimitReset   = 8'd1;
  localparam logic [CntWidth-1:0] OnThresholdReset  = 8'd1;
  localparam logic [CntWidth-1:0] OffThresholdReset = 8'd0;
  localparam logic [PinWidth-1:0] InvertMaskReset   = 8'h00;
  localparam logic [PinWidth-1:0] EnableMaskReset   = 8'hFF;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_COUNT_LIMIT   = 3'd0,
    CFG_ON_THRESHOLD  = 3'd1,
    CFG_OFF_THRESHOLD = 3'd2,
    CFG_INVERT_MASK   = 3'd3,
    CFG_ENABLE_MASK   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CntWidth-1:0] count_limit;
    logic [CntWidth-1:0] on_threshold;
    logic [CntWidth-1:0] off_threshold;
  } thr_cfg_t;

  typedef struct packed {
    logic step;
    logic pin;
    logic enable;
  } lane_ctl_t;

endpackage

@@ sv/bidb_lane.sv @@
// One integrating debounce lane: saturating counter with hysteresis level.
// Depends on bidb_pkg.
module bidb_lane import bidb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  thr_cfg_t  cfg_i,
  output logic      level_o
);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                level_q, level_d;

  always_comb begin
    cnt_d   = cnt_q;
    level_d = level_q;
    if (ctl_i.step && ctl_i.enable) begin
      if (ctl_i.pin) begin
        // a counter left above a lowered limit holds
        if (cnt_q < cfg_i.count_limit) begin
          cnt_d = cnt_q + CntWidth'(1);
        end
        if (cnt_d >= cfg_i.on_threshold) begin
          level_d = 1'b1;
        end
      end else begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CntWidth'(1);
        end
        if (cnt_d <= cfg_i.off_threshold) begin
          level_d = 1'b0;
        end
      end
    end
  end

  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      level_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

endmodule

@@ sv/bidb_merge.sv @@
// Merge stage: masks and inverts lane levels into the result word and
// holds it in the output register. Depends on bidb_pkg.
module bidb_merge import bidb_pkg::*; #(
  parameter int unsigned LaneCount = LaneCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [LaneCount-1:0] level_i,
  input  logic [PinWidth-1:0]  invert_i,
  input  logic [PinWidth-1:0]  enable_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output logic [PinWidth-1:0]  data_o
);

  logic [PinWidth-1:0] result;
  logic [PinWidth-1:0] data_q;
  logic                valid_q, valid_d;

  for (genvar i = 0; i < PinWidth; i++) begin : g_bit
    if (i < LaneCount) begin : g_lane
      assign result[i] = enable_i[i] & (level_i[i] ^ invert_i[i]);
    end else begin : g_none
      assign result[i] = 1'b0;
    end
  end

  // take a new item whenever the register is empty or the held one leaves in the same cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

@@ sv/boolean_input_debounce_bank_top.sv @@
// Debounce bank usage notes:
// Input channel in_valid_i/in_ready_o carries one raw pin vector per item;
// output channel out_valid_o/out_ready_i carries the filtered level vector.
// Each item steps every enabled lane's counter by one unless saturated and
// yields exactly one result; out_valid_o rises in the cycle after acceptance.
// Unstalled throughput is one item per cycle: all lanes update in parallel
// in the accepting cycle; the merge stage's output register holds the result.
// While the receiver stalls, the held result stays put; in_ready_o stays high
// as long as the output register is empty or drains in the same cycle.
// Registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i with no
// wait; indexes past the register list are ignored. Write only while idle.
// Reset (rst_ni low, asynchronous) clears all counters and levels and loads
// count limit 1, on threshold 1, off threshold 0, no inversion, all lanes
// enabled. Lanes from index 8 (PinWidth) up see a low pin and stay frozen.
// Depends on bidb_pkg, bidb_lane and bidb_merge.
module boolean_input_debounce_bank_top import bidb_pkg::*; #(
  parameter int unsigned LaneCount = LaneCountDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PinWidth-1:0]      raw_pins_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PinWidth-1:0]      filtered_levels_o
);

  thr_cfg_t            thr_q;
  logic [PinWidth-1:0] invert_q;
  logic [PinWidth-1:0] enable_q;
  logic                accept;
  logic [LaneCount-1:0] level_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.count_limit   <= CountLimitReset;
      thr_q.on_threshold  <= OnThresholdReset;
      thr_q.off_threshold <= OffThresholdReset;
      invert_q            <= InvertMaskReset;
      enable_q            <= EnableMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COUNT_LIMIT:   thr_q.count_limit   <= cfg_wdata_i;
        CFG_ON_THRESHOLD:  thr_q.on_threshold  <= cfg_wdata_i;
        CFG_OFF_THRESHOLD: thr_q.off_threshold <= cfg_wdata_i;
        CFG_INVERT_MASK:   invert_q            <= cfg_wdata_i;
        CFG_ENABLE_MASK:   enable_q            <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  for (genvar i = 0; i < LaneCount; i++) begin : g_lane
    lane_ctl_t ctl;
    if (i < PinWidth) begin : g_pin
      assign ctl = '{step: accept, pin: raw_pins_i[i], enable: enable_q[i]};
    end else begin : g_frozen
      assign ctl = '{step: accept, pin: 1'b0, enable: 1'b0};
    end

    bidb_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .cfg_i   (thr_q),
      .level_o (level_next[i])
    );
  end

  bidb_merge #(
    .LaneCount (LaneCount)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .level_i     (level_next),
    .invert_i    (invert_q),
    .enable_i    (enable_q),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .data_o      (filtered_levels_o)
  );

endmodule

@@ sv/bidb_checker.sv @@
// Port-level checker for the debounce bank, bound to the top level.
// Depends on bidb_pkg and the assertion macro header.
`include "boolean_input_debounce_bank_top_macros.svh"

module bidb_checker import bidb_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [PinWidth-1:0]      filtered_levels_o
);

  `BIDB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(filtered_levels_o), "stalled result changed or dropped")

  `BIDB_ASSERT_NEXT(a_item_yields_result, clk_i, rst_ni, in_valid_i && in_ready_o,
    out_valid_o, "accepted item gave no result")

  `BIDB_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without backpressure")

  `BIDB_ASSERT_NEXT(a_no_extra_result, clk_i, rst_ni,
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o),
    !out_valid_o, "result repeated after delivery")

endmodule

bind boolean_input_debounce_bank_top bidb_checker u_bidb_checker (.*);

@@ sim/tb_boolean_input_debounce_bank_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for boolean_input_debounce_bank_top: random pin runs with bounce
// noise, register sweeps and handshake stalls, checked against a lane-level predictor.
// Depends on bidb_pkg and the block's RTL only.
module tb_boolean_input_debounce_bank_top;
  import bidb_pkg::*;

  localparam logic [CfgIndexWidth-1:0] CfgIndexFirstUnused = 3'd5;
  localparam logic [CfgIndexWidth-1:0] CfgIndexLast        = {CfgIndexWidth{1'b1}};
  localparam int unsigned SegmentItems = 138;
  localparam int unsigned LongHoldCycles = 80;

  // Tracks every lane's counter and level and queues the expected level vectors.
  class debounce_scoreboard;
    logic [CntWidth-1:0] limit_reg, on_reg, off_reg;
    logic [PinWidth-1:0] invert_reg, enable_reg;
    logic [CntWidth-1:0] lane_count [LaneCountDefault];
    logic                lane_on    [LaneCountDefault];
    logic [PinWidth-1:0] expected_levels [$];
    int unsigned items_noted, results_checked, mismatches, reg_writes;

    function new();
      limit_reg  = CountLimitReset;
      on_reg     = OnThresholdReset;
      off_reg    = OffThresholdReset;
      invert_reg = InvertMaskReset;
      enable_reg = EnableMaskReset;
      foreach (lane_count[i]) begin
        lane_count[i] = '0;
        lane_on[i]    = 1'b0;
      end
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      reg_writes++;
      case (cfg_reg_e'(idx))
        CFG_COUNT_LIMIT:   limit_reg  = data;
        CFG_ON_THRESHOLD:  on_reg     = data;
        CFG_OFF_THRESHOLD: off_reg    = data;
        CFG_INVERT_MASK:   invert_reg = data;
        CFG_ENABLE_MASK:   enable_reg = data;
        default: ;
      endcase
    endfunction

    function void note_pins(logic [PinWidth-1:0] pins);
      logic [PinWidth-1:0] levels;
      levels = '0;
      for (int i = 0; i < LaneCountDefault; i++) begin
        if (enable_reg[i]) begin
          if (pins[i]) begin
            // a counter already above the limit stays put
            if (lane_count[i] < limit_reg) lane_count[i] = lane_count[i] + 1'b1;
            if (lane_count[i] >= on_reg) lane_on[i] = 1'b1;
          end else begin
            if (lane_count[i] != '0) lane_count[i] = lane_count[i] - 1'b1;
            if (lane_count[i] <= off_reg) lane_on[i] = 1'b0;
          end
          levels[i] = lane_on[i] ^ invert_reg[i];
        end
      end
      expected_levels.push_back(levels);
      items_noted++;
    endfunction

    function void check_levels(logic [PinWidth-1:0] got);
      logic [PinWidth-1:0] want;
      results_checked++;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h", $time, got);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        if (got !== want) begin
          $display("%0t: filtered_levels mismatch, expected %02h, actual %02h",
                   $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [PinWidth-1:0]      raw_pins_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [PinWidth-1:0]      filtered_levels_o;

  debounce_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned run_len = 4;
  int unsigned noise_pct = 10;
  bit          long_hold_arm = 1'b0;
  logic [PinWidth-1:0] lane_truth = '0;

  boolean_input_debounce_bank_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_pins_i       (raw_pins_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_levels_o(filtered_levels_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sample both channels and the register port on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_levels(filtered_levels_o);
      if (in_valid_i && in_ready_o) sb.note_pins(raw_pins_i);
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_wdata_i);
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && long_hold_arm) begin
        long_hold_arm = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Mostly steady lane levels that flip now and then, with bounce noise on top; some vectors are fully random.
  function automatic logic [PinWidth-1:0] next_pins();
    logic [PinWidth-1:0] pins;
    if ($urandom_range(99) < 15) return PinWidth'($urandom_range(2**PinWidth - 1));
    for (int i = 0; i < PinWidth; i++) begin
      if ($urandom_range(run_len - 1) == 0) lane_truth[i] = ~lane_truth[i];
      pins[i] = lane_truth[i] ^ ($urandom_range(99) < noise_pct);
    end
    return pins;
  endfunction

  // Called at a clock edge; returns at the edge that accepts the item.
  task automatic send_pins(input logic [PinWidth-1:0] pins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_pins_i <= pins;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CntWidth-1:0] limit, input logic [CntWidth-1:0] on_thr,
                              input logic [CntWidth-1:0] off_thr,
                              input logic [PinWidth-1:0] invert, input logic [PinWidth-1:0] enable);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_COUNT_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_index_i <= CFG_ON_THRESHOLD;
    cfg_wdata_i <= on_thr;
    @(posedge clk_i);
    cfg_index_i <= CFG_OFF_THRESHOLD;
    cfg_wdata_i <= off_thr;
    @(posedge clk_i);
    cfg_index_i <= CFG_INVERT_MASK;
    cfg_wdata_i <= invert;
    @(posedge clk_i);
    cfg_index_i <= CFG_ENABLE_MASK;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    // an index past the register list must leave everything as is
    cfg_index_i <= CfgIndexWidth'($urandom_range(CfgIndexLast, CfgIndexFirstUnused));
    cfg_wdata_i <= CfgDataWidth'($urandom_range(2**CfgDataWidth - 1));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CntWidth-1:0] limit_v, on_v, off_v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one step on, one step off.
    send_pins('0);
    send_pins('1);
    send_pins('1);
    send_pins('0);
    settle();
    apply_config(8'd8, 8'd6, 8'd2, 8'h5A, 8'hFF);
    repeat (8) send_pins('1);
    settle();
    // Limit drops below the counters; upper lanes frozen.
    apply_config(8'd3, 8'd3, 8'd1, 8'h00, 8'h0F);
    send_pins('1);
    send_pins('1);
    send_pins('0);
    send_pins('0);
    settle();
    // Zero limit: counters never climb, on threshold zero still turns lanes on.
    apply_config(8'd0, 8'd0, 8'd0, 8'hFF, 8'hF0);
    send_pins('0);
    send_pins('1);
    send_pins(8'h3C);
    settle();
    // On threshold below off threshold.
    apply_config(8'd255, 8'd1, 8'd254, 8'h00, 8'hFF);
    send_pins('1);
    send_pins('0);
    send_pins(8'h81);
    send_pins(8'h7E);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 20; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      limit_v   = CntWidth'($urandom_range(15, 1));
      on_v      = CntWidth'($urandom_range(16));
      off_v     = CntWidth'($urandom_range(16));
      run_len   = $urandom_range(12, 2);
      noise_pct = 10;
      case (seg)
        1: begin limit_v = 8'd255; on_v = 8'd0; off_v = 8'd255; run_len = 20; end
        3: begin limit_v = 8'd255; on_v = 8'd20; off_v = 8'd10; run_len = 60; noise_pct = 3; end
        5: begin
          limit_v = CntWidth'($urandom_range(3));
          on_v    = CntWidth'($urandom_range(4));
          off_v   = 8'd0;
        end
        default: ;
      endcase
      apply_config(limit_v, on_v, off_v, PinWidth'($urandom_range(2**PinWidth - 1)),
                   (seg == 1) ? {PinWidth{1'b1}}
                              : PinWidth'($urandom_range(2**PinWidth - 1)));
      if (seg == 4) long_hold_arm = 1'b1;
      repeat (SegmentItems) send_pins(next_pins());
      settle();
    end

    $display("Covered %0d pin vectors and %0d results over %0d register writes,",
             sb.items_noted, sb.results_checked, sb.reg_writes);
    $display("with saturation, frozen lanes, inversion and crossed thresholds; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d results still outstanding", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
